>>> rtl/bmp_pkg.sv
`default_nettype none
package bmp_pkg;

  // Frame header bytes and the broadcast flag in the fifth byte.
  localparam logic [7:0] HDR_BYTE0 = 8'h81;
  localparam logic [7:0] HDR_BYTE1 = 8'h7B;
  localparam logic [7:0] HDR_BYTE2 = 8'h20;
  localparam logic [7:0] BCAST_MASK = 8'h02;
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;

  // Fixed frame offsets.
  localparam logic [7:0] POS_HDR0 = 8'd0;
  localparam logic [7:0] POS_HDR1 = 8'd1;
  localparam logic [7:0] POS_HDR2 = 8'd2;
  localparam logic [7:0] POS_FLAGS = 8'd4;
  localparam logic [7:0] POS_POLL = 8'd5;
  localparam logic [7:0] POS_BODY = 8'd6;
  localparam logic [7:0] POS_MAX = 8'd255;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_PIPE = 2'd1;

  typedef enum logic [2:0] {
    EV_DRIVE = 3'd0,
    EV_POLL = 3'd1,
    EV_BAD_LENGTH = 3'd2,
    EV_NO_PIPE = 3'd3,
    EV_OVERFLOW = 3'd4
  } event_kind_t;

  // What a body byte left behind for emission.
  typedef enum logic [1:0] {
    BODY_NONE,
    BODY_BAD_LENGTH,
    BODY_NO_PIPE,
    BODY_DRIVE
  } body_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_BODY,
    ST_DRIVE,
    ST_OVF,
    ST_POLL
  } state_t;

  typedef struct packed {
    logic take;
    logic step;
    event_kind_t kind;
  } bmp_cmd_t;

  typedef struct packed {
    body_kind_t body;
    logic ovf;
    logic poll;
    logic run_end;
  } bmp_status_t;

endpackage
`default_nettype wire

>>> rtl/bmp_if.sv
`default_nettype none
interface bmp_in_if;
  logic valid;
  logic ready;
  logic [7:0] rx_byte;
  logic radio_index;
  logic frame_end;

  modport source(output valid, rx_byte, radio_index, frame_end, input ready);
  modport sink(input valid, rx_byte, radio_index, frame_end, output ready);
endinterface

interface bmp_out_if;
  logic valid;
  logic ready;
  logic [2:0] event_kind;
  logic [5:0] drive_index;
  logic [7:0] drive_value;
  logic run_last;

  modport source(output valid, event_kind, drive_index, drive_value, run_last,
                 input ready);
  modport sink(input valid, event_kind, drive_index, drive_value, run_last,
               output ready);
endinterface

interface bmp_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/broadcast_micropacket_parser_unit.sv
`default_nettype none
// Broadcast micropacket parser. The block takes a received radio frame one
// byte per input transaction and checks the frame header (0x81, 0x7B, 0x20),
// the broadcast flag in byte 4, that the frame came from radio 0 and that it
// is at least six bytes long. Byte 5 is the poll code. From byte 6 on the
// frame is cut into length-prefixed micropackets whose header byte carries a
// robot number (high nibble) and a pipe number (low nibble). A micropacket
// for this robot on the drive pipe with exactly DRIVE_BYTES data bytes is
// staged and then sent out as a run of DRIVE_BYTES drive byte results. A bad
// length, an unknown pipe for this robot, or a frame that ends inside a
// micropacket gives one error result and stops parsing of that frame; the
// poll check on the final byte still happens. Bytes beyond FRAME_BYTES are
// ignored. Each input byte passes an acceptance state and then a decision
// state, and each of its results is given when the output is ready; the
// result sequencer handles one byte at a time and the input stays not ready
// until the last result of the byte has been taken. Configuration writes
// are taken in any cycle and should only be made while the block is idle.
module broadcast_micropacket_parser_unit
  import bmp_pkg::*;
#(
  parameter int DRIVE_BYTES = 10,
  parameter int FRAME_BYTES = 128
) (
  input wire logic   clk,
  input wire logic   rst,
  bmp_in_if.sink     in_ch,
  bmp_out_if.source  out_ch,
  bmp_cfg_if.sink    cfg
);

  logic [3:0] robot_id;
  logic [3:0] drive_pipe_id;
  bmp_cmd_t    cmd;
  bmp_status_t status;

  // Configuration registers. Writes to indexes beyond the list are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      robot_id <= 4'd0;
      drive_pipe_id <= 4'd0;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_ROBOT_ID) begin
        robot_id <= cfg.data[3:0];
      end else if (cfg.index == CFG_DRIVE_PIPE) begin
        drive_pipe_id <= cfg.data[3:0];
      end
    end
  end

  // The controller sequences acceptance and the results of each byte.
  bmp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .run_last (out_ch.run_last),
    .cmd      (cmd),
    .status   (status)
  );

  // The datapath holds the frame state, the staging store and the run counter.
  bmp_datapath #(
    .DRIVE_BYTES(DRIVE_BYTES),
    .FRAME_BYTES(FRAME_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .robot_id     (robot_id),
    .drive_pipe_id(drive_pipe_id),
    .rx_byte      (in_ch.rx_byte),
    .radio_index  (in_ch.radio_index),
    .frame_end    (in_ch.frame_end),
    .cmd          (cmd),
    .status       (status),
    .event_kind   (out_ch.event_kind),
    .drive_index  (out_ch.drive_index),
    .drive_value  (out_ch.drive_value)
  );

endmodule
`default_nettype wire

>>> rtl/bmp_ctrl.sv
`default_nettype none
module bmp_ctrl
  import bmp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             run_last,
  output bmp_cmd_t         cmd,
  input  wire bmp_status_t status
);

  state_t state, state_next;
  logic out_fire;

  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status.body == BODY_BAD_LENGTH || status.body == BODY_NO_PIPE) begin
          state_next = ST_BODY;
        end else if (status.body == BODY_DRIVE) begin
          state_next = ST_DRIVE;
        end else if (status.ovf) begin
          state_next = ST_OVF;
        end else if (status.poll) begin
          state_next = ST_POLL;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_BODY, ST_DRIVE: begin
        if (out_fire && (state == ST_BODY || status.run_end)) begin
          if (status.ovf) state_next = ST_OVF;
          else if (status.poll) state_next = ST_POLL;
          else state_next = ST_IDLE;
        end
      end
      ST_OVF: begin
        if (out_fire) state_next = status.poll ? ST_POLL : ST_IDLE;
      end
      ST_POLL: begin
        if (out_fire) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_valid = 1'b0;
    run_last = 1'b0;
    cmd.take = 1'b0;
    cmd.step = 1'b0;
    cmd.kind = EV_DRIVE;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_DECIDE: begin
      end
      ST_BODY: begin
        out_valid = 1'b1;
        cmd.kind = (status.body == BODY_NO_PIPE) ? EV_NO_PIPE : EV_BAD_LENGTH;
        run_last = !status.ovf && !status.poll;
      end
      ST_DRIVE: begin
        out_valid = 1'b1;
        cmd.kind = EV_DRIVE;
        cmd.step = out_fire;
        run_last = status.run_end && !status.ovf && !status.poll;
      end
      ST_OVF: begin
        out_valid = 1'b1;
        cmd.kind = EV_OVERFLOW;
        run_last = !status.poll;
      end
      ST_POLL: begin
        out_valid = 1'b1;
        cmd.kind = EV_POLL;
        run_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/bmp_datapath.sv
`default_nettype none
module bmp_datapath
  import bmp_pkg::*;
#(
  parameter int DRIVE_BYTES = 10,
  parameter int FRAME_BYTES = 128
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [3:0] robot_id,
  input  wire logic [3:0] drive_pipe_id,
  input  wire logic [7:0] rx_byte,
  input  wire logic       radio_index,
  input  wire logic       frame_end,
  input  wire bmp_cmd_t   cmd,
  output bmp_status_t     status,
  output logic [2:0]      event_kind,
  output logic [5:0]      drive_index,
  output logic [7:0]      drive_value
);

  localparam int DIDX_W = (DRIVE_BYTES > 1) ? $clog2(DRIVE_BYTES) : 1;
  localparam logic [7:0] FRAME_LIMIT = 8'(FRAME_BYTES);
  localparam logic [7:0] DRIVE_LEN = 8'(DRIVE_BYTES + 2);
  localparam logic [7:0] DRIVE_CNT = 8'(DRIVE_BYTES);
  localparam logic [DIDX_W-1:0] RUN_END = DIDX_W'(DRIVE_BYTES - 1);

  logic [7:0] frame_position, frame_position_next;
  logic       frame_accepted, frame_accepted_next;
  logic [7:0] poll_code, poll_code_next;
  logic [7:0] chunk_length, chunk_length_next;
  logic [7:0] chunk_offset, chunk_offset_next;
  logic [7:0] chunk_address, chunk_address_next;
  logic       parse_halted, parse_halted_next;
  logic [7:0] drive_stage [DRIVE_BYTES];

  logic             stage_we;
  logic [DIDX_W-1:0] stage_addr;
  body_kind_t       body_next, body_q;
  logic             ovf_next, ovf_q;
  logic             poll_next, poll_q;
  logic [DIDX_W-1:0] run_cnt;

  always_comb begin
    logic [7:0] off_inc;
    logic [7:0] addr_eff;
    logic [7:0] d;
    logic [3:0] robot;
    logic [3:0] pipe;

    frame_position_next = frame_position;
    frame_accepted_next = frame_accepted;
    poll_code_next = poll_code;
    chunk_length_next = chunk_length;
    chunk_offset_next = chunk_offset;
    chunk_address_next = chunk_address;
    parse_halted_next = parse_halted;
    stage_we = 1'b0;
    body_next = BODY_NONE;
    ovf_next = 1'b0;
    poll_next = 1'b0;
    off_inc = chunk_offset + 8'd1;
    addr_eff = (chunk_offset == 8'd1) ? rx_byte : chunk_address;
    d = chunk_offset - 8'd2;
    stage_addr = d[DIDX_W-1:0];
    robot = addr_eff[7:4];
    pipe = addr_eff[3:0];

    if (frame_position < FRAME_LIMIT) begin
      if (frame_position == POS_HDR0) begin
        frame_accepted_next = (rx_byte == HDR_BYTE0) && !radio_index;
        parse_halted_next = 1'b0;
        chunk_offset_next = 8'd0;
        chunk_length_next = 8'd0;
        chunk_address_next = 8'd0;
      end else if (frame_position == POS_HDR1) begin
        frame_accepted_next = frame_accepted && (rx_byte == HDR_BYTE1);
      end else if (frame_position == POS_HDR2) begin
        frame_accepted_next = frame_accepted && (rx_byte == HDR_BYTE2);
      end else if (frame_position == POS_FLAGS) begin
        frame_accepted_next = frame_accepted && ((rx_byte & BCAST_MASK) != 8'd0);
      end else if (frame_position == POS_POLL) begin
        poll_code_next = rx_byte;
      end else if (frame_position >= POS_BODY && frame_accepted && !parse_halted) begin
        if (chunk_offset == 8'd0) begin
          // Length byte of a new micropacket; it counts itself.
          chunk_length_next = rx_byte;
          if (rx_byte < 8'd2) begin
            parse_halted_next = 1'b1;
            body_next = BODY_BAD_LENGTH;
          end else begin
            chunk_offset_next = 8'd1;
          end
        end else begin
          if (chunk_offset == 8'd1) begin
            chunk_address_next = rx_byte;
          end else if (d < DRIVE_CNT && robot != 4'd0 && robot == robot_id &&
                       pipe == drive_pipe_id) begin
            stage_we = 1'b1;
          end
          chunk_offset_next = off_inc;
          if (off_inc == chunk_length) begin
            chunk_offset_next = 8'd0;
            if (robot != 4'd0 && robot == robot_id) begin
              if (pipe != drive_pipe_id) begin
                parse_halted_next = 1'b1;
                body_next = BODY_NO_PIPE;
              end else if (chunk_length != DRIVE_LEN) begin
                parse_halted_next = 1'b1;
                body_next = BODY_BAD_LENGTH;
              end else begin
                body_next = BODY_DRIVE;
              end
            end
          end
        end
      end
    end

    if (frame_end) begin
      if (frame_accepted_next && frame_position >= POS_POLL) begin
        ovf_next = !parse_halted_next && (chunk_offset_next != 8'd0);
        poll_next = (poll_code_next != 8'd0) &&
                    (poll_code_next == {4'd0, robot_id});
      end
      frame_position_next = 8'd0;
      frame_accepted_next = 1'b0;
      chunk_offset_next = 8'd0;
      parse_halted_next = 1'b0;
    end else if (frame_position < POS_MAX) begin
      frame_position_next = frame_position + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= 8'd0;
      frame_accepted <= 1'b0;
      poll_code <= 8'd0;
      chunk_length <= 8'd0;
      chunk_offset <= 8'd0;
      chunk_address <= 8'd0;
      parse_halted <= 1'b0;
      body_q <= BODY_NONE;
      ovf_q <= 1'b0;
      poll_q <= 1'b0;
      run_cnt <= '0;
    end else if (cmd.take) begin
      frame_position <= frame_position_next;
      frame_accepted <= frame_accepted_next;
      poll_code <= poll_code_next;
      chunk_length <= chunk_length_next;
      chunk_offset <= chunk_offset_next;
      chunk_address <= chunk_address_next;
      parse_halted <= parse_halted_next;
      body_q <= body_next;
      ovf_q <= ovf_next;
      poll_q <= poll_next;
      run_cnt <= '0;
    end else if (cmd.step) begin
      run_cnt <= run_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && stage_we) begin
      drive_stage[stage_addr] <= rx_byte;
    end
  end

  assign status.body = body_q;
  assign status.ovf = ovf_q;
  assign status.poll = poll_q;
  assign status.run_end = (run_cnt == RUN_END);

  assign event_kind = cmd.kind;
  assign drive_index = (cmd.kind == EV_DRIVE) ? 6'(run_cnt) : 6'd0;
  assign drive_value = (cmd.kind == EV_DRIVE) ? drive_stage[run_cnt] : 8'd0;

endmodule
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import bmp_pkg::*;

  // Block sizing, kept at the block's defaults.
  localparam int DRIVE_BYTES = 10;
  localparam int FRAME_BYTES = 128;

  // A micropacket length counts its own length byte and its header byte.
  localparam int MIN_CHUNK = 2;
  localparam int DRIVE_CHUNK = MIN_CHUNK + DRIVE_BYTES;

  // One frame runs well past FRAME_BYTES, so its tail has to be ignored.
  localparam int LONG_FRAME = FRAME_BYTES + 24;

  // This settling time covers any byte still in flight that owes no result.
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 35;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    event_kind_t kind;
    logic [5:0] index;
    logic [7:0] value;
    logic last;
  } drive_event_t;

  // The scoreboard carries its own copy of the parser state and of the two
  // settings registers. Every accepted byte is run through that copy, and the
  // events the byte should cause are queued in order of emission.
  class micropacket_scoreboard;
    logic [3:0] robot;
    logic [3:0] pipe;
    logic [7:0] frame_pos;
    logic accepted;
    logic [7:0] poll_code;
    logic [7:0] chunk_len;
    logic [7:0] chunk_off;
    logic [7:0] chunk_addr;
    logic [7:0] stage[DRIVE_BYTES];
    logic halted;
    drive_event_t awaited[$];
    int errors;

    function new();
      robot = 4'h0;
      pipe = 4'h0;
      frame_pos = 8'h00;
      accepted = 1'b0;
      poll_code = 8'h00;
      chunk_len = 8'h00;
      chunk_off = 8'h00;
      chunk_addr = 8'h00;
      halted = 1'b0;
      errors = 0;
      foreach (stage[i]) stage[i] = 8'h00;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void set_register(logic [1:0] idx, logic [7:0] data);
      if (idx == CFG_ROBOT_ID) robot = data[3:0];
      else if (idx == CFG_DRIVE_PIPE) pipe = data[3:0];
    endfunction

    function void add_result(event_kind_t kind, int idx, logic [7:0] value);
      drive_event_t ev;
      ev.kind = kind;
      ev.index = 6'(idx);
      ev.value = value;
      ev.last = 1'b0;
      awaited.push_back(ev);
    endfunction

    // Robot zero is nobody, so it never matches even when robot_id is zero.
    function logic addressed_here();
      return chunk_addr[7:4] != 4'h0 && chunk_addr[7:4] == robot;
    endfunction

    function void close_chunk();
      chunk_off = 8'h00;
      if (!addressed_here()) return;
      if (chunk_addr[3:0] != pipe) begin
        halted = 1'b1;
        add_result(EV_NO_PIPE, 0, 8'h00);
      end else if (chunk_len != DRIVE_CHUNK) begin
        halted = 1'b1;
        add_result(EV_BAD_LENGTH, 0, 8'h00);
      end else begin
        for (int k = 0; k < DRIVE_BYTES; k++) add_result(EV_DRIVE, k, stage[k]);
      end
    endfunction

    function void body_byte(logic [7:0] b);
      int d;
      if (chunk_off == 8'h00) begin
        chunk_len = b;
        if (b < MIN_CHUNK) begin
          halted = 1'b1;
          add_result(EV_BAD_LENGTH, 0, 8'h00);
        end else begin
          chunk_off = 8'h01;
        end
        return;
      end
      if (chunk_off == 8'h01) begin
        chunk_addr = b;
      end else begin
        d = chunk_off - 2;
        if (d < DRIVE_BYTES && addressed_here() && chunk_addr[3:0] == pipe) stage[d] = b;
      end
      chunk_off = chunk_off + 8'h01;
      if (chunk_off == chunk_len) close_chunk();
    endfunction

    function void note_input(logic [7:0] b, logic radio, logic fend);
      int unsigned p;
      int first;
      drive_event_t tail;
      p = frame_pos;
      first = awaited.size();
      if (p < FRAME_BYTES) begin
        if (p == POS_HDR0) begin
          accepted = (b == HDR_BYTE0) && !radio;
          halted = 1'b0;
          chunk_off = 8'h00;
          chunk_len = 8'h00;
          chunk_addr = 8'h00;
        end else if (p == POS_HDR1) begin
          accepted = accepted && (b == HDR_BYTE1);
        end else if (p == POS_HDR2) begin
          accepted = accepted && (b == HDR_BYTE2);
        end else if (p == POS_FLAGS) begin
          accepted = accepted && ((b & BCAST_MASK) != 8'h00);
        end else if (p == POS_POLL) begin
          poll_code = b;
        end else if (p >= POS_BODY && accepted && !halted) begin
          body_byte(b);
        end
      end
      if (fend) begin
        if (accepted && p >= POS_POLL) begin
          if (!halted && chunk_off != 8'h00) begin
            halted = 1'b1;
            add_result(EV_OVERFLOW, 0, 8'h00);
          end
          if (poll_code != 8'h00 && poll_code == {4'h0, robot}) add_result(EV_POLL, 0, 8'h00);
        end
        frame_pos = 8'h00;
        accepted = 1'b0;
        chunk_off = 8'h00;
        halted = 1'b0;
      end else if (frame_pos != POS_MAX) begin
        frame_pos = frame_pos + 8'h01;
      end
      if (awaited.size() > first) begin
        tail = awaited.pop_back();
        tail.last = 1'b1;
        awaited.push_back(tail);
      end
    endfunction

    task report(string msg);
      if (errors < 40) $display("%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [2:0] kind, logic [5:0] idx, logic [7:0] value, logic last);
      drive_event_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing awaited: kind %0d index %0d value %02h last %0b",
                         kind, idx, value, last));
        return;
      end
      want = awaited.pop_front();
      if (kind !== want.kind || idx !== want.index || value !== want.value ||
          last !== want.last)
        report($sformatf("got kind %0d index %0d value %02h last %0b, wanted %0d %0d %02h %0b",
                         kind, idx, value, last, want.kind, want.index, want.value,
                         want.last));
    endtask
  endclass

  logic clk;
  logic rst;

  bmp_in_if in_ch();
  bmp_out_if out_ch();
  bmp_cfg_if cfg_ch();

  broadcast_micropacket_parser_unit #(
    .DRIVE_BYTES(DRIVE_BYTES),
    .FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg(cfg_ch)
  );

  micropacket_scoreboard sb = new();

  // Idling odds, in percent per cycle, set by the phase that is running.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // The frame being built, and the radio it claims to come from.
  logic [7:0] frame_q[$];
  logic frame_radio;

  // The long receiver hold-off is started once by the stimulus and timed by
  // a process of its own.
  bit hold_go = 1'b0;
  logic rx_hold;
  int cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a run that stops making progress ends here as a failure.
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    rx_hold <= 1'b0;
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Result side. The transaction is judged on the values present before the
  // edge, and then ready is chosen for the next cycle.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.event_kind, out_ch.drive_index, out_ch.drive_value,
                        out_ch.run_last);
      out_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  // Offer one byte and hold it until the block takes it. Valid is left high
  // afterwards so that back-to-back bytes never see it drop for a step.
  task automatic send_item(input logic [7:0] b, input logic radio, input logic fend);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    in_ch.radio_index <= radio;
    in_ch.frame_end <= fend;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(b, radio, fend);
  endtask

  // The radio is only looked at on the first byte; later bytes carry noise.
  task automatic send_frame();
    int i;
    for (i = 0; i < frame_q.size(); i++)
      send_item(frame_q[i], (i == 0) ? frame_radio : 1'($urandom_range(1)),
                i == frame_q.size() - 1);
  endtask

  // Append the first `keep` bytes of a micropacket of length `len`.
  task automatic push_chunk(input int len, input logic [7:0] addr, input int keep);
    int i;
    for (i = 0; i < keep; i++) begin
      if (i == 0) frame_q.push_back(8'(len));
      else if (i == 1) frame_q.push_back(addr);
      else frame_q.push_back(rand_byte());
    end
  endtask

  // A frame with a valid header and a mix of micropackets. Nearly half go to this
  // robot on the drive pipe; the rest exercise other robots, a foreign pipe,
  // wrong and illegal lengths, and a frame cut off inside a micropacket.
  task automatic build_good_frame(input int chunks);
    int i;
    int pick;
    int len;
    logic [3:0] nib;
    frame_radio = 1'b0;
    frame_q.delete();
    frame_q.push_back(HDR_BYTE0);
    frame_q.push_back(HDR_BYTE1);
    frame_q.push_back(HDR_BYTE2);
    frame_q.push_back(rand_byte());
    frame_q.push_back(rand_byte() | BCAST_MASK);
    case ($urandom_range(3))
      0: frame_q.push_back({4'h0, sb.robot});
      1: frame_q.push_back(8'h00);
      default: frame_q.push_back(rand_byte());
    endcase
    for (i = 0; i < chunks; i++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        push_chunk(DRIVE_CHUNK, {sb.robot, sb.pipe}, DRIVE_CHUNK);
      end else if (pick < 60) begin
        nib = 4'($urandom_range(15));
        if (nib == sb.robot) nib = 4'h0;
        len = $urandom_range(MIN_CHUNK, 16);
        push_chunk(len, {nib, 4'($urandom_range(15))}, len);
      end else if (pick < 68) begin
        nib = sb.pipe ^ 4'($urandom_range(1, 15));
        len = $urandom_range(MIN_CHUNK, 6);
        push_chunk(len, {sb.robot, nib}, len);
      end else if (pick < 76) begin
        len = $urandom_range(MIN_CHUNK, 20);
        if (len == DRIVE_CHUNK) len = MIN_CHUNK;
        push_chunk(len, {sb.robot, sb.pipe}, len);
      end else if (pick < 84) begin
        push_chunk($urandom_range(MIN_CHUNK - 1), rand_byte(), 1);
      end else begin
        push_chunk(DRIVE_CHUNK, {sb.robot, sb.pipe}, $urandom_range(1, DRIVE_CHUNK - 1));
        break;
      end
    end
  endtask

  // Frames the block must reject or that carry nothing but noise.
  task automatic build_noise_frame();
    int k;
    build_good_frame($urandom_range(2));
    case ($urandom_range(4))
      0: begin
        frame_q.delete();
        repeat ($urandom_range(1, 8)) frame_q.push_back(rand_byte());
      end
      1: begin
        k = $urandom_range(2);
        frame_q[k] = frame_q[k] ^ 8'($urandom_range(1, 255));
      end
      2: frame_radio = 1'b1;
      3: frame_q[POS_FLAGS] = frame_q[POS_FLAGS] & ~BCAST_MASK;
      default: begin
        k = $urandom_range(1, 5);
        while (frame_q.size() > k) void'(frame_q.pop_back());
      end
    endcase
  endtask

  // Both registers are written back to back; the upper data bits are noise
  // that the block has to drop.
  task automatic write_settings(input logic [3:0] robot_id, input logic [3:0] pipe_id);
    int r;
    logic [7:0] wdata;
    for (r = CFG_ROBOT_ID; r <= CFG_DRIVE_PIPE; r++) begin
      wdata = {4'($urandom_range(15)), (r == CFG_ROBOT_ID) ? robot_id : pipe_id};
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= 2'(r);
      cfg_ch.data <= wdata;
      do @(posedge clk); while (!cfg_ch.ready);
      sb.set_register(2'(r), wdata);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random frames until the phase has sent about `target` bytes, rejected
  // frames included.
  task automatic run_phase(input int target);
    int sent;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(99) < 75) begin
        build_good_frame($urandom_range(0, 4));
      end else begin
        build_noise_frame();
      end
      sent += frame_q.size();
      send_frame();
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    in_ch.radio_index <= 1'b0;
    in_ch.frame_end <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_ROBOT_ID;
    cfg_ch.data <= 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part: a full drive micropacket with byte extremes and a
    // matching poll, then a frame whose first micropacket has an illegal
    // length and no poll.
    write_settings(4'h5, 4'h3);
    frame_radio = 1'b0;
    frame_q = '{HDR_BYTE0, HDR_BYTE1, HDR_BYTE2, 8'hFF, BCAST_MASK, 8'h05,
                8'(DRIVE_CHUNK), 8'h53, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE,
                8'h55, 8'hAA, 8'h33, 8'hCC};
    send_frame();
    frame_q = '{HDR_BYTE0, HDR_BYTE1, HDR_BYTE2, 8'h00, 8'hFF, 8'h00, 8'h01};
    send_frame();
    in_ch.valid <= 1'b0;
    wait_quiet();

    // No idling, apart from one long receiver hold-off while bytes keep
    // coming, so the block backs up and stops taking input. The long frame
    // runs past FRAME_BYTES with a micropacket straddling the cut.
    write_settings(4'hF, 4'hF);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_go = 1'b1;
    build_good_frame(0);
    while (frame_q.size() < FRAME_BYTES + 10)
      push_chunk(DRIVE_CHUNK, {sb.robot, sb.pipe}, DRIVE_CHUNK);
    while (frame_q.size() < LONG_FRAME) frame_q.push_back(rand_byte());
    send_frame();
    run_phase(PHASE_ITEMS);
    wait_quiet();

    write_settings(4'h1, 4'h0);
    send_idle_pct = 58;
    recv_stall_pct = 0;
    run_phase(PHASE_ITEMS);
    wait_quiet();

    // Robot zero matches nothing: only illegal lengths and overflows remain.
    write_settings(4'h0, 4'h7);
    send_idle_pct = 0;
    recv_stall_pct = 58;
    run_phase(PHASE_ITEMS);
    wait_quiet();

    write_settings(4'hA, 4'hC);
    send_idle_pct = 22;
    recv_stall_pct = 22;
    run_phase(PHASE_ITEMS);
    wait_quiet();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
